// ----- hw/rtl/snf_pkg.sv -----
// ----------------------------------------------------------------------------
// snf_pkg: shared types and constants of the source nesting scanner
// Opcodes, character classes, scanner modes, the queued command and the result.
// ----------------------------------------------------------------------------
`default_nettype none

package snf_pkg;

	// Input opcodes. Code 3 leaves all state alone.
	typedef enum logic [1:0] {
		OP_TEXT  = 2'd0,
		OP_EOL   = 2'd1,
		OP_CLEAR = 2'd2,
		OP_NOP   = 2'd3
	} op_t;

	// Character classes produced by the front end.
	typedef enum logic [3:0] {
		CLS_SPACE  = 4'd0,
		CLS_LBRACK = 4'd1,
		CLS_RBRACK = 4'd2,
		CLS_SEMI   = 4'd3,
		CLS_LPAREN = 4'd4,
		CLS_RPAREN = 4'd5,
		CLS_QUOTE  = 4'd6,
		CLS_TICK   = 4'd7,
		CLS_BSLASH = 4'd8,
		CLS_COLON  = 4'd9,
		CLS_OTHER  = 4'd10
	} cls_t;

	// Scanner modes.
	typedef enum logic [2:0] {
		MODE_NORMAL  = 3'd0,
		MODE_WORD    = 3'd1,
		MODE_TICK    = 3'd2,
		MODE_LINECMT = 3'd3,
		MODE_STRING  = 3'd4,
		MODE_STR_ESC = 3'd5
	} mode_t;

	// Character codes.
	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_TICK   = 8'h27;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_COLON  = 8'h3A;
	localparam logic [7:0] CH_SEMI   = 8'h3B;
	localparam logic [7:0] CH_LBRACK = 8'h5B;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_RBRACK = 8'h5D;

	// Queue depths between the parts.
	localparam int CMD_DEPTH = 2;
	localparam int RES_DEPTH = 2;

	// Classified command from the front end to the back end.
	typedef struct packed {
		op_t  op;
		cls_t cls;
	} cmd_t;

	// Result transaction.
	typedef struct packed {
		logic              complete;
		logic signed [7:0] brackets;
		logic [7:0]        comments;
		logic              str_open;
	} res_t;

endpackage

`default_nettype wire

// ----- hw/rtl/snf_fifo.sv -----
// ----------------------------------------------------------------------------
// snf_fifo: small register queue
// First-in first-out queue with push/full and pop/empty sides, shown-ahead read.
// ----------------------------------------------------------------------------
`default_nettype none

module snf_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] wdata,
	output logic                  full,
	input  wire logic             pop,
	output logic [WIDTH-1:0]      rdata,
	output logic                  empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			unique case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	// Storage needs no reset.
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

endmodule

`default_nettype wire

// ----- hw/rtl/snf_front.sv -----
// ----------------------------------------------------------------------------
// snf_front: input classifier and command queue
// Maps each incoming character to a class and queues the command for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module snf_front (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	input  wire logic [1:0]  opcode,
	input  wire logic [7:0]  char_code,
	output logic             full,
	input  wire logic        cmd_pop,
	output snf_pkg::cmd_t    cmd,
	output logic             cmd_empty
);

	localparam int CMD_W = $bits(snf_pkg::cmd_t);

	snf_pkg::cmd_t    cmd_in;
	logic [CMD_W-1:0] cmd_bits;

	// Character classification. A newline byte sent as text acts as end of line.
	always_comb begin
		cmd_in.op = snf_pkg::op_t'(opcode);
		unique case (char_code)
			snf_pkg::CH_NUL,
			snf_pkg::CH_TAB,
			snf_pkg::CH_CR,
			snf_pkg::CH_SPACE:  cmd_in.cls = snf_pkg::CLS_SPACE;
			snf_pkg::CH_LBRACK: cmd_in.cls = snf_pkg::CLS_LBRACK;
			snf_pkg::CH_RBRACK: cmd_in.cls = snf_pkg::CLS_RBRACK;
			snf_pkg::CH_SEMI:   cmd_in.cls = snf_pkg::CLS_SEMI;
			snf_pkg::CH_LPAREN: cmd_in.cls = snf_pkg::CLS_LPAREN;
			snf_pkg::CH_RPAREN: cmd_in.cls = snf_pkg::CLS_RPAREN;
			snf_pkg::CH_QUOTE:  cmd_in.cls = snf_pkg::CLS_QUOTE;
			snf_pkg::CH_TICK:   cmd_in.cls = snf_pkg::CLS_TICK;
			snf_pkg::CH_BSLASH: cmd_in.cls = snf_pkg::CLS_BSLASH;
			snf_pkg::CH_COLON:  cmd_in.cls = snf_pkg::CLS_COLON;
			default:            cmd_in.cls = snf_pkg::CLS_OTHER;
		endcase
		if (cmd_in.op == snf_pkg::OP_TEXT && char_code == snf_pkg::CH_LF) begin
			cmd_in.op = snf_pkg::OP_EOL;
		end
	end

	// Command queue toward the back end.
	snf_fifo #(
		.WIDTH(CMD_W),
		.DEPTH(snf_pkg::CMD_DEPTH)
	) u_cmd_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.wdata (cmd_in),
		.full  (full),
		.pop   (cmd_pop),
		.rdata (cmd_bits),
		.empty (cmd_empty)
	);

	assign cmd = snf_pkg::cmd_t'(cmd_bits);

endmodule

`default_nettype wire

// ----- hw/rtl/snf_exec.sv -----
// ----------------------------------------------------------------------------
// snf_exec: scanner state machine
// Applies one queued command per cycle, while the result queue has room, to the nesting state and forms the result.
// ----------------------------------------------------------------------------
`default_nettype none

module snf_exec #(
	parameter int DEPTH_BITS = 8
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire snf_pkg::cmd_t  cmd,
	input  wire logic           cmd_empty,
	output logic                cmd_pop,
	input  wire logic           res_full,
	output logic                res_push,
	output snf_pkg::res_t       res
);

	localparam int EXT_W = (DEPTH_BITS > 8) ? DEPTH_BITS : 9;

	localparam logic signed [DEPTH_BITS-1:0] NEST_MAX = {1'b0, {(DEPTH_BITS-1){1'b1}}};
	localparam logic signed [DEPTH_BITS-1:0] NEST_MIN = {1'b1, {(DEPTH_BITS-1){1'b0}}};
	localparam logic signed [DEPTH_BITS-1:0] NEST_ONE = 1;
	localparam logic [DEPTH_BITS-1:0]        CMT_MAX  = '1;
	localparam logic [DEPTH_BITS-1:0]        CMT_ONE  = 1;
	localparam logic signed [EXT_W-1:0]      OB_MAX   = 127;
	localparam logic signed [EXT_W-1:0]      OB_MIN   = -128;
	localparam logic [EXT_W-1:0]             OC_MAX   = 255;

	snf_pkg::mode_t                mode_q, mode_d;
	logic signed [DEPTH_BITS-1:0]  nest_q, nest_d;
	logic [DEPTH_BITS-1:0]         cmt_q, cmt_d;
	logic                          colon_q, colon_d;
	logic                          fire;
	logic                          delim;
	logic                          go_top;
	logic                          in_str;
	logic signed [EXT_W-1:0]       nest_ext;
	logic [EXT_W-1:0]              cmt_ext;

	// One command goes through whenever there is one and the result queue has room.
	assign fire     = !cmd_empty && !res_full;
	assign cmd_pop  = fire;
	assign res_push = fire;

	// Delimiters that end a word; newline never reaches here as text.
	assign delim = (cmd.cls == snf_pkg::CLS_SPACE)  || (cmd.cls == snf_pkg::CLS_LBRACK) ||
	               (cmd.cls == snf_pkg::CLS_RBRACK) || (cmd.cls == snf_pkg::CLS_SEMI)   ||
	               (cmd.cls == snf_pkg::CLS_LPAREN) || (cmd.cls == snf_pkg::CLS_RPAREN) ||
	               (cmd.cls == snf_pkg::CLS_QUOTE)  || (cmd.cls == snf_pkg::CLS_TICK);

	// Next-state logic.
	always_comb begin
		mode_d  = mode_q;
		nest_d  = nest_q;
		cmt_d   = cmt_q;
		colon_d = colon_q;
		go_top  = 1'b0;
		unique case (cmd.op)
			snf_pkg::OP_EOL: begin
				if (mode_q == snf_pkg::MODE_STR_ESC) begin
					mode_d = snf_pkg::MODE_STRING;
				end else if (mode_q != snf_pkg::MODE_STRING) begin
					if (mode_q == snf_pkg::MODE_WORD && colon_q && nest_d != NEST_MAX) begin
						nest_d = nest_d + NEST_ONE;
					end
					colon_d = 1'b0;
					mode_d  = snf_pkg::MODE_NORMAL;
				end
			end
			snf_pkg::OP_CLEAR: begin
				mode_d  = snf_pkg::MODE_NORMAL;
				nest_d  = '0;
				cmt_d   = '0;
				colon_d = 1'b0;
			end
			snf_pkg::OP_TEXT: begin
				priority if (mode_q == snf_pkg::MODE_STR_ESC) begin
					mode_d = snf_pkg::MODE_STRING;
				end else if (mode_q == snf_pkg::MODE_STRING) begin
					if (cmd.cls == snf_pkg::CLS_BSLASH) begin
						mode_d = snf_pkg::MODE_STR_ESC;
					end else if (cmd.cls == snf_pkg::CLS_QUOTE) begin
						mode_d = snf_pkg::MODE_NORMAL;
					end
				end else if (cmt_q != '0) begin
					if (cmd.cls == snf_pkg::CLS_LPAREN) begin
						if (cmt_q != CMT_MAX) begin
							cmt_d = cmt_q + CMT_ONE;
						end
					end else if (cmd.cls == snf_pkg::CLS_RPAREN) begin
						cmt_d = cmt_q - CMT_ONE;
					end
				end else if (mode_q == snf_pkg::MODE_LINECMT) begin
					mode_d = mode_q;
				end else if (mode_q == snf_pkg::MODE_WORD || mode_q == snf_pkg::MODE_TICK) begin
					if (!delim) begin
						colon_d = 1'b0;
					end else begin
						// The word ends here; a lone colon word opens a bracket.
						if (mode_q == snf_pkg::MODE_WORD && colon_q && nest_d != NEST_MAX) begin
							nest_d = nest_d + NEST_ONE;
						end
						colon_d = 1'b0;
						mode_d  = snf_pkg::MODE_NORMAL;
						go_top  = 1'b1;
					end
				end else begin
					go_top = 1'b1;
				end
				// Handling of a character between tokens.
				if (go_top) begin
					unique case (cmd.cls)
						snf_pkg::CLS_SPACE,
						snf_pkg::CLS_RPAREN: mode_d = mode_d;
						snf_pkg::CLS_BSLASH: mode_d = snf_pkg::MODE_LINECMT;
						snf_pkg::CLS_LPAREN: cmt_d  = CMT_ONE;
						snf_pkg::CLS_QUOTE:  mode_d = snf_pkg::MODE_STRING;
						snf_pkg::CLS_LBRACK: begin
							if (nest_d != NEST_MAX) begin
								nest_d = nest_d + NEST_ONE;
							end
						end
						snf_pkg::CLS_RBRACK,
						snf_pkg::CLS_SEMI: begin
							if (nest_d != NEST_MIN) begin
								nest_d = nest_d - NEST_ONE;
							end
						end
						snf_pkg::CLS_TICK:   mode_d = snf_pkg::MODE_TICK;
						default: begin
							mode_d  = snf_pkg::MODE_WORD;
							colon_d = (cmd.cls == snf_pkg::CLS_COLON);
						end
					endcase
				end
			end
			// The unused opcode, and an empty queue slot, leave the state alone.
			default: begin
				mode_d = mode_q;
			end
		endcase
	end

	// Result formed from the state after the command.
	always_comb begin
		in_str   = (mode_d == snf_pkg::MODE_STRING) || (mode_d == snf_pkg::MODE_STR_ESC);
		nest_ext = EXT_W'(nest_d);
		cmt_ext  = EXT_W'(cmt_d);
		res.complete = (nest_d[DEPTH_BITS-1] || nest_d == '0) && (cmt_d == '0) && !in_str;
		if (nest_ext > OB_MAX) begin
			res.brackets = 8'sd127;
		end else if (nest_ext < OB_MIN) begin
			res.brackets = -8'sd128;
		end else begin
			res.brackets = nest_ext[7:0];
		end
		res.comments = (cmt_ext > OC_MAX) ? 8'hFF : cmt_ext[7:0];
		res.str_open = in_str;
	end

	// State registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= snf_pkg::MODE_NORMAL;
			nest_q  <= '0;
			cmt_q   <= '0;
			colon_q <= 1'b0;
		end else if (fire) begin
			mode_q  <= mode_d;
			nest_q  <= nest_d;
			cmt_q   <= cmt_d;
			colon_q <= colon_d;
		end
	end

	// A clear returns every state register to its reset value.
	a_clear_resets: assert property (@(posedge clk) disable iff (!arst_n)
		fire && cmd.op == snf_pkg::OP_CLEAR |=>
		nest_q == '0 && cmt_q == '0 && mode_q == snf_pkg::MODE_NORMAL && !colon_q)
		else $error("clear did not reset the scanner state");

	// The unused opcode leaves the state alone.
	a_nop_holds: assert property (@(posedge clk) disable iff (!arst_n)
		fire && cmd.op == snf_pkg::OP_NOP |=>
		$stable(nest_q) && $stable(cmt_q) && $stable(mode_q) && $stable(colon_q))
		else $error("unused opcode changed the scanner state");

	// A string is only ever opened outside of a paren comment.
	a_string_no_comment: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q == snf_pkg::MODE_STRING || mode_q == snf_pkg::MODE_STR_ESC) |-> cmt_q == '0)
		else $error("string open inside a paren comment");

	// The colon flag only lives inside a plain word.
	a_colon_in_word: assert property (@(posedge clk) disable iff (!arst_n)
		colon_q |-> mode_q == snf_pkg::MODE_WORD)
		else $error("colon flag set outside a word");

endmodule

`default_nettype wire

// ----- hw/rtl/source_nesting_scanner.sv -----
// ----------------------------------------------------------------------------
// source_nesting_scanner: bracket, comment and string tracker for source text
// Path: an input transaction is registered in the command queue, and its result in the result queue.
// Throughput: one transaction per cycle while the result queue has room.
// The command queue and the result queue decouple the two sides.
// Reset: arst_n clears the scanner state and both queues at once.
// ----------------------------------------------------------------------------
`default_nettype none

module source_nesting_scanner #(
	parameter int DEPTH_BITS = 8
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	output logic             full,
	input  wire logic [1:0]  opcode,
	input  wire logic [7:0]  char_code,
	output logic             empty,
	input  wire logic        pop,
	output logic             expression_complete,
	output logic signed [7:0] open_brackets,
	output logic [7:0]       open_comments,
	output logic             string_open
);

	localparam int RES_W = $bits(snf_pkg::res_t);

	snf_pkg::cmd_t    cmd;
	logic             cmd_empty;
	logic             cmd_pop;
	logic             res_full;
	logic             res_push;
	snf_pkg::res_t    res_in;
	snf_pkg::res_t    res_out;
	logic [RES_W-1:0] res_bits;

	// Front end: classify and queue.
	snf_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.opcode   (opcode),
		.char_code(char_code),
		.full     (full),
		.cmd_pop  (cmd_pop),
		.cmd      (cmd),
		.cmd_empty(cmd_empty)
	);

	// Back end: scanner state machine.
	snf_exec #(
		.DEPTH_BITS(DEPTH_BITS)
	) u_exec (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.cmd_empty(cmd_empty),
		.cmd_pop  (cmd_pop),
		.res_full (res_full),
		.res_push (res_push),
		.res      (res_in)
	);

	// Result queue toward the consumer.
	snf_fifo #(
		.WIDTH(RES_W),
		.DEPTH(snf_pkg::RES_DEPTH)
	) u_res_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (res_push),
		.wdata (res_in),
		.full  (res_full),
		.pop   (pop),
		.rdata (res_bits),
		.empty (empty)
	);

	assign res_out             = snf_pkg::res_t'(res_bits);
	assign expression_complete = res_out.complete;
	assign open_brackets       = res_out.brackets;
	assign open_comments       = res_out.comments;
	assign string_open         = res_out.str_open;

endmodule

`default_nettype wire

// ----- tb/nesting_checker.sv -----
// ----------------------------------------------------------------------------
// nesting_checker: result checker for the source nesting scanner
// Watches both queue interfaces, tracks bracket, comment and string state of
// every accepted input transaction, and compares each popped result in order.
// ----------------------------------------------------------------------------
module nesting_checker #(
	parameter int DEPTH_BITS = 8
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	input  wire logic        full,
	input  wire logic [1:0]  opcode,
	input  wire logic [7:0]  char_code,
	input  wire logic        empty,
	input  wire logic        pop,
	input  wire logic        expression_complete,
	input  wire logic signed [7:0] open_brackets,
	input  wire logic [7:0]  open_comments,
	input  wire logic        string_open,
	output int               fail_count,
	output int               pending
);
	timeunit 1ns;
	timeprecision 1ps;

	import snf_pkg::*;

	localparam int NEST_MAX = (1 << (DEPTH_BITS - 1)) - 1;
	localparam int NEST_MIN = -(1 << (DEPTH_BITS - 1));

	// Tracked scanner state.
	mode_t                         mode = MODE_NORMAL;
	logic signed [DEPTH_BITS-1:0]  nest = '0;
	logic [DEPTH_BITS-1:0]         depth = '0;
	logic                          colon_only = 1'b0;

	// Status words owed by the block, oldest first.
	res_t due_status[$];
	res_t oldest;
	int   mismatches = 0;

	function automatic logic is_ws(input logic [7:0] ch);
		return ch == CH_SPACE || ch == CH_TAB || ch == CH_CR || ch == CH_NUL;
	endfunction

	function automatic void nest_up();
		if (nest < NEST_MAX) nest = DEPTH_BITS'(nest + 1);
	endfunction

	// A word ends; a word that is exactly a colon opens a bracket level.
	function automatic void close_word();
		if (mode == MODE_WORD && colon_only) nest_up();
		colon_only = 1'b0;
		mode = MODE_NORMAL;
	endfunction

	// Strings survive the line end, but a pending escape does not.
	function automatic void end_of_line();
		if (mode == MODE_STR_ESC) mode = MODE_STRING;
		else if (mode != MODE_STRING) close_word();
	endfunction

	function automatic void clear_state();
		mode = MODE_NORMAL;
		nest = '0;
		depth = '0;
		colon_only = 1'b0;
	endfunction

	// Applies one input transaction and returns the status after it.
	function automatic res_t scan_step(input op_t op, input logic [7:0] ch);
		res_t status;
		logic at_top;
		logic in_str;
		int   nb;

		case (op)
			OP_TEXT: begin
				if (ch == CH_LF) begin
					end_of_line();
				end else if (mode == MODE_STR_ESC) begin
					mode = MODE_STRING;
				end else if (mode == MODE_STRING) begin
					if (ch == CH_BSLASH) mode = MODE_STR_ESC;
					else if (ch == CH_QUOTE) mode = MODE_NORMAL;
				end else if (depth != 0) begin
					// Inside a paren comment only parens count.
					if (ch == CH_LPAREN) begin
						if (depth != '1) depth = depth + 1'b1;
					end else if (ch == CH_RPAREN) begin
						depth = depth - 1'b1;
					end
				end else if (mode != MODE_LINECMT) begin
					at_top = 1'b1;
					if (mode == MODE_WORD || mode == MODE_TICK) begin
						if (is_ws(ch) || ch == CH_LBRACK || ch == CH_RBRACK ||
						    ch == CH_SEMI || ch == CH_LPAREN || ch == CH_RPAREN ||
						    ch == CH_QUOTE || ch == CH_TICK) begin
							close_word();
						end else begin
							colon_only = 1'b0;
							at_top = 1'b0;
						end
					end
					// Between tokens; a stray close paren is skipped.
					if (at_top && !is_ws(ch) && ch != CH_RPAREN) begin
						if (ch == CH_BSLASH) mode = MODE_LINECMT;
						else if (ch == CH_LPAREN) depth = DEPTH_BITS'(1);
						else if (ch == CH_QUOTE) mode = MODE_STRING;
						else if (ch == CH_LBRACK) nest_up();
						else if (ch == CH_RBRACK || ch == CH_SEMI) begin
							if (nest > NEST_MIN) nest = DEPTH_BITS'(nest - 1);
						end else if (ch == CH_TICK) mode = MODE_TICK;
						else begin
							mode = MODE_WORD;
							colon_only = (ch == CH_COLON);
						end
					end
				end
			end
			OP_EOL: end_of_line();
			OP_CLEAR: clear_state();
			default: ;
		endcase

		in_str = (mode == MODE_STRING || mode == MODE_STR_ESC);
		nb = nest;
		if (nb > 127) nb = 127;
		if (nb < -128) nb = -128;
		status.complete = (nest <= 0) && (depth == 0) && !in_str;
		status.brackets = nb[7:0];
		status.comments = (depth > 255) ? 8'hFF : 8'(depth);
		status.str_open = in_str;
		return status;
	endfunction

	task automatic check_field(input string name, input int want, input int got);
		if (want != got) begin
			$display("%0t ns: %s mismatch, expected %0d, actual %0d",
			         $time, name, want, got);
			mismatches++;
		end
	endtask

	// Compare popped results in order, then record the new input transaction.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_state();
			due_status.delete();
		end else begin
			if (pop && !empty) begin
				if (due_status.size() == 0) begin
					$display({"%0t ns: result with no transaction waiting, ",
					          "expected none, actual %0d %0d %0d %0d"},
					         $time, expression_complete, open_brackets, open_comments,
					         string_open);
					mismatches++;
				end else begin
					oldest = due_status.pop_front();
					check_field("expression_complete", oldest.complete, expression_complete);
					check_field("open_brackets", oldest.brackets, open_brackets);
					check_field("open_comments", oldest.comments, open_comments);
					check_field("string_open", oldest.str_open, string_open);
				end
			end
			if (push && !full) due_status.push_back(scan_step(op_t'(opcode), char_code));
		end
		pending = due_status.size();
		fail_count = mismatches;
	end

endmodule

// ----- tb/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench: top level for the source nesting scanner
// Drives characters, line ends and clears through the input queue, pops results
// with random stalls, and reports the verdict of the result checker.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import snf_pkg::*;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        push = 1'b0;
	logic        pop = 1'b0;
	logic [1:0]  opcode = OP_TEXT;
	logic [7:0]  char_code = CH_NUL;
	logic        full;
	logic        empty;
	logic        expression_complete;
	logic signed [7:0] open_brackets;
	logic [7:0]  open_comments;
	logic        string_open;

	int   fail_count;
	int   pending;
	int   item_count = 0;
	int   push_idle_pct = 0;
	int   pop_idle_pct = 0;
	logic calm = 1'b0;

	always #6 clk = ~clk;

	source_nesting_scanner #(
		.DEPTH_BITS(8)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.opcode(opcode),
		.char_code(char_code),
		.empty(empty),
		.pop(pop),
		.expression_complete(expression_complete),
		.open_brackets(open_brackets),
		.open_comments(open_comments),
		.string_open(string_open)
	);

	nesting_checker #(
		.DEPTH_BITS(8)
	) status_check (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.opcode(opcode),
		.char_code(char_code),
		.empty(empty),
		.pop(pop),
		.expression_complete(expression_complete),
		.open_brackets(open_brackets),
		.open_comments(open_comments),
		.string_open(string_open),
		.fail_count(fail_count),
		.pending(pending)
	);

	// Idle rates shift over the run; zero gives stretches with no gaps.
	function automatic int pick_idle_pct();
		case ($urandom_range(0, 2))
			0: return 0;
			1: return 15;
			default: return 50;
		endcase
	endfunction

	function automatic logic [7:0] random_letter();
		return 8'(8'h61 + $urandom_range(0, 25));
	endfunction

	function automatic logic [7:0] random_byte();
		return 8'($urandom_range(0, 255));
	endfunction

	// Offers one input transaction and waits until the queue takes it.
	task automatic send_item(input logic [1:0] op, input logic [7:0] ch);
		if (!calm && push_idle_pct != 0 && $urandom_range(1, 100) <= push_idle_pct) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
		push <= 1'b1;
		opcode <= op;
		char_code <= ch;
		@(posedge clk);
		while (full) @(posedge clk);
		item_count++;
		if (item_count % 100 == 0) push_idle_pct = pick_idle_pct();
	endtask

	task automatic send_char(input logic [7:0] ch);
		send_item(OP_TEXT, ch);
	endtask

	// A line end comes either as its own opcode or as a newline byte.
	task automatic send_eol();
		if ($urandom_range(0, 1)) send_item(OP_EOL, random_byte());
		else send_char(CH_LF);
	endtask

	// Result side: pop with random stall bursts.
	initial begin
		int stall_left;
		stall_left = 0;
		forever begin
			@(posedge clk);
			if (stall_left > 0 && !calm) begin
				stall_left--;
				pop <= 1'b0;
			end else if (!calm && pop_idle_pct != 0 &&
			             $urandom_range(1, 100) <= pop_idle_pct) begin
				stall_left = $urandom_range(0, 15);
				pop <= 1'b0;
			end else begin
				pop <= 1'b1;
			end
			if ($urandom_range(1, 200) == 1) pop_idle_pct = pick_idle_pct();
		end
	end

	// Stimulus and verdict.
	initial begin
		int token_idx;
		int n;
		logic [7:0] deep_ch;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: every opcode, pending colon words, stray parens,
		// nested comments, escapes across a line end, odd bytes.
		send_item(OP_NOP, 8'hFF);
		send_char(CH_LBRACK);
		send_char(CH_COLON);
		send_char(CH_SPACE);
		send_char(CH_COLON);
		send_item(OP_EOL, CH_NUL);
		send_char(CH_RBRACK);
		send_char(CH_SEMI);
		send_char(CH_RPAREN);
		send_char(CH_LPAREN);
		send_char(CH_LPAREN);
		send_char(CH_RPAREN);
		send_char(CH_RPAREN);
		send_char(CH_QUOTE);
		send_char(CH_BSLASH);
		send_item(OP_EOL, 8'hFF);
		send_char(CH_QUOTE);
		send_char(CH_QUOTE);
		send_char(CH_BSLASH);
		send_char(CH_LBRACK);
		send_char(CH_LF);
		send_char(CH_TICK);
		send_char(CH_COLON);
		send_char(CH_NUL);
		send_char(8'hFF);
		send_char(CH_TAB);
		send_char(CH_CR);
		send_item(OP_CLEAR, 8'hFF);

		// Random token streams, with deep runs that reach the depth limits.
		token_idx = 0;
		while (item_count < 1030) begin
			if (item_count >= 880) calm = 1'b1;
			if (token_idx % 30 == 5) begin
				send_item(OP_CLEAR, random_byte());
				case ((token_idx / 30) % 3)
					0: begin
						deep_ch = CH_LPAREN;
						n = $urandom_range(256, 270);
					end
					1: begin
						deep_ch = CH_LBRACK;
						n = $urandom_range(128, 160);
					end
					default: begin
						deep_ch = CH_RBRACK;
						n = $urandom_range(129, 160);
					end
				endcase
				repeat (n) send_char(deep_ch);
				send_item(OP_CLEAR, random_byte());
			end else begin
				case ($urandom_range(0, 19))
					0, 1, 2, 3, 4, 5: begin
						// Word, sometimes a lone colon or a double colon.
						if ($urandom_range(0, 3) == 0) begin
							send_char(CH_COLON);
							if ($urandom_range(0, 2) == 0) send_char(CH_COLON);
						end else begin
							repeat ($urandom_range(1, 6))
								send_char($urandom_range(0, 4) == 0 ?
								          CH_COLON : random_letter());
						end
						case ($urandom_range(0, 5))
							0: send_eol();
							1: begin
								case ($urandom_range(0, 10))
									0: send_char(CH_TAB);
									1: send_char(CH_CR);
									2: send_char(CH_NUL);
									3: send_char(CH_LBRACK);
									4: send_char(CH_RBRACK);
									5: send_char(CH_SEMI);
									6: send_char(CH_LPAREN);
									7: send_char(CH_RPAREN);
									8: send_char(CH_QUOTE);
									9: send_char(CH_TICK);
									default: send_char(CH_SPACE);
								endcase
							end
							default: send_char(CH_SPACE);
						endcase
					end
					6, 7, 8: begin
						case ($urandom_range(0, 3))
							0, 1: send_char(CH_LBRACK);
							2: send_char(CH_RBRACK);
							default: send_char(CH_SEMI);
						endcase
						send_char(CH_SPACE);
					end
					9, 10: begin
						// Paren comment with some content, maybe nested.
						send_char(CH_LPAREN);
						repeat ($urandom_range(0, 5)) begin
							case ($urandom_range(0, 5))
								0: send_char(CH_LPAREN);
								1: send_char(CH_RPAREN);
								2: send_char(CH_QUOTE);
								3: send_eol();
								4: send_char(CH_LBRACK);
								default: send_char(random_letter());
							endcase
						end
						send_char(CH_RPAREN);
					end
					11, 12: begin
						// String with escapes, some left pending at a line end.
						send_char(CH_QUOTE);
						repeat ($urandom_range(0, 6)) begin
							case ($urandom_range(0, 5))
								0: begin
									send_char(CH_BSLASH);
									send_char(random_byte());
								end
								1: begin
									send_char(CH_BSLASH);
									send_eol();
								end
								2: send_char(CH_LPAREN);
								3: send_char(CH_SPACE);
								4: send_char(random_letter());
								default: send_eol();
							endcase
						end
						send_char(CH_QUOTE);
					end
					13: begin
						send_char(CH_BSLASH);
						repeat ($urandom_range(0, 5)) send_char(random_byte());
						send_eol();
					end
					14: begin
						send_char(CH_TICK);
						repeat ($urandom_range(0, 4))
							send_char($urandom_range(0, 2) == 0 ? CH_COLON : random_letter());
						send_char(CH_SPACE);
					end
					15: send_eol();
					16, 17, 18: send_item(2'($urandom_range(0, 3)), random_byte());
					default: send_item(OP_CLEAR, random_byte());
				endcase
			end
			token_idx++;
		end
		push <= 1'b0;

		// Drain: wait for every owed result.
		@(negedge clk);
		while (pending != 0) @(negedge clk);
		repeat (10) @(negedge clk);
		if (fail_count == 0 && pending == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

	// Run limit.
	initial begin
		#20000000;
		$display("Some tests failed");
		$finish;
	end

endmodule

// ----- source_nesting_scanner.f -----
hw/rtl/snf_pkg.sv
hw/rtl/snf_fifo.sv
hw/rtl/snf_front.sv
hw/rtl/snf_exec.sv
hw/rtl/source_nesting_scanner.sv
tb/nesting_checker.sv
tb/testbench.sv
